/* design/lttc_pkg.sv */
// Shared types and constants for the line tracker turn controller.
`default_nettype none

package lttc_pkg;

	// Drive commands sent to the motor stage
	typedef enum logic [2:0] {
		CMD_STOP       = 3'd0,
		CMD_FORWARD    = 3'd1,
		CMD_VEER_LEFT  = 3'd2,
		CMD_VEER_RIGHT = 3'd3,
		CMD_TURN_LEFT  = 3'd4,
		CMD_TURN_RIGHT = 3'd5
	} cmd_t;

	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 16;

	// Register indexes on the config port
	typedef enum logic [CfgIdxW-1:0] {
		REG_NO_RIGHT_RELOAD   = 2'd0,
		REG_SPIN_BLOCK_RELOAD = 2'd1,
		REG_STOP_WINDOW       = 2'd2
	} reg_idx_t;

	localparam logic [7:0]  NoRightReloadRst   = 8'd80;
	localparam logic [7:0]  SpinBlockReloadRst = 8'd50;
	localparam logic [15:0] StopWindowRst      = 16'd50;
	localparam logic [15:0] StopCountMax       = 16'hFFFF;

endpackage

`default_nettype wire

/* design/line_tracker_turn_controller_core.sv */
// Top level of the line tracker turn controller: decision logic and result register.
`default_nettype none

// Line tracker turn controller.
// Input channel (in_valid / in_stall) carries one control tick: five line
// sensor bits. Output channel (out_valid / out_stall) carries one result item
// per tick: the drive command, a flag that it differs from the last issued
// command, and a pulse when a right 90 crossing turn begins.
// The result of a tick is in the result register in the cycle after the
// tick is taken. Throughput: one tick per cycle unless the receiver stalls;
// all decisions are a single pass of compare/count logic on the controller
// state, so the state register loop sets the rate at one item per cycle.
// When the receiver stalls, the result register holds its item and in_stall
// rises; a new tick is still taken in the cycle the held item leaves.
// Config port: cfg_we writes cfg_data into the register at cfg_index
// (0 no-right reload, 1 spin-block reload, 2 stop window); other indexes are
// ignored. Write only while no item is in flight.
// Reset (arst_n low, asynchronous): holds, counters and previous sensor bits
// clear, command returns to stop, reloads go to 80 / 50 and stop window to 50,
// the result register empties.
module line_tracker_turn_controller_core (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire                          sensor_l2,
	input  wire                          sensor_l1,
	input  wire                          sensor_mid,
	input  wire                          sensor_r1,
	input  wire                          sensor_r2,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic [2:0]                   drive_command,
	output logic                         command_changed,
	output logic                         right_turn_started,
	input  wire                          cfg_we,
	input  wire  [lttc_pkg::CfgIdxW-1:0] cfg_index,
	input  wire  [lttc_pkg::CfgDataW-1:0] cfg_data
);
	import lttc_pkg::*;

	// config registers
	logic [7:0]  no_right_reload_q;
	logic [7:0]  spin_block_reload_q;
	logic [15:0] stop_window_q;

	// controller state
	logic        prev_l2_q, prev_l1_q, prev_r1_q, prev_r2_q;
	logic        hold_left_q, hold_spin_q, hold_cross_q;
	logic [15:0] right_stop_q, left_stop_q;
	logic [7:0]  spin_block_q, no_right_q;
	cmd_t        cmd_q;

	// next state
	logic        hold_left_n, hold_spin_n, hold_cross_n;
	logic [15:0] right_stop_n, left_stop_n;
	logic [7:0]  spin_block_n, no_right_n;
	cmd_t        cmd_n;
	logic        started_n;
	logic [15:0] right_inc, left_inc;
	logic        r1_rise, l1_rise;

	// result register
	logic        out_valid_q;
	cmd_t        out_cmd_q;
	logic        out_changed_q, out_started_q;

	logic        in_take;

	assign in_stall = out_valid_q && out_stall;
	assign in_take  = in_valid && !in_stall;

	assign out_valid          = out_valid_q;
	assign drive_command      = out_cmd_q;
	assign command_changed    = out_changed_q;
	assign right_turn_started = out_started_q;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			no_right_reload_q   <= NoRightReloadRst;
			spin_block_reload_q <= SpinBlockReloadRst;
			stop_window_q       <= StopWindowRst;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NO_RIGHT_RELOAD:   no_right_reload_q   <= cfg_data[7:0];
				REG_SPIN_BLOCK_RELOAD: spin_block_reload_q <= cfg_data[7:0];
				REG_STOP_WINDOW:       stop_window_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	assign right_inc = (right_stop_q == StopCountMax) ? right_stop_q : right_stop_q + 16'd1;
	assign left_inc  = (left_stop_q == StopCountMax) ? left_stop_q : left_stop_q + 16'd1;
	assign r1_rise   = sensor_r1 && !prev_r1_q;
	assign l1_rise   = sensor_l1 && !prev_l1_q;

	// One tick of the decision chain.
	always_comb begin
		// countdowns drop first
		spin_block_n = (spin_block_q != 8'd0) ? spin_block_q - 8'd1 : spin_block_q;
		no_right_n   = (no_right_q != 8'd0) ? no_right_q - 8'd1 : no_right_q;
		hold_left_n  = hold_left_q;
		hold_spin_n  = hold_spin_q;
		hold_cross_n = hold_cross_q;
		right_stop_n = right_stop_q;
		left_stop_n  = left_stop_q;
		cmd_n        = cmd_q;
		started_n    = 1'b0;

		if (hold_left_q) begin
			// left 90 ends on inner-left rising edge, then block right turns
			if (l1_rise) begin
				hold_left_n = 1'b0;
				no_right_n  = no_right_reload_q;
			end
		end else if (hold_spin_q) begin
			if (r1_rise)
				hold_spin_n = 1'b0;
		end else if (hold_cross_q) begin
			if (r1_rise && spin_block_n == 8'd0)
				hold_cross_n = 1'b0;
		end else begin
			if (sensor_r2) begin
				right_stop_n = right_inc;
				if (sensor_l2)
					left_stop_n = left_inc;
			end else if (!sensor_l2 && prev_l2_q) begin
				// outer left just dropped: left 90 if mid is off and no crossing was seen
				if (!sensor_mid && left_stop_q == 16'd0) begin
					right_stop_n = 16'd0;
					left_stop_n  = 16'd0;
					cmd_n        = CMD_TURN_LEFT;
					hold_left_n  = 1'b1;
				end
			end else if (!sensor_l2 && !prev_l2_q && !prev_r2_q) begin
				if (sensor_l1)
					cmd_n = CMD_VEER_LEFT;
				else if (sensor_r1)
					cmd_n = CMD_VEER_RIGHT;
				else if (!sensor_mid) begin
					// line lost: spin right until the inner right sees it
					cmd_n       = CMD_TURN_RIGHT;
					hold_spin_n = 1'b1;
				end else
					cmd_n = CMD_FORWARD;
				right_stop_n = 16'd0;
				left_stop_n  = 16'd0;
			end

			// short right-edge pulse that ended: right 90 at a crossing
			if (right_stop_n != 16'd0 && right_stop_n < stop_window_q &&
			    !sensor_r2 && no_right_n == 8'd0) begin
				started_n    = 1'b1;
				right_stop_n = 16'd0;
				left_stop_n  = 16'd0;
				spin_block_n = spin_block_reload_q;
				cmd_n        = CMD_TURN_RIGHT;
				hold_cross_n = 1'b1;
			end
		end
	end

	// state update on each accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_l2_q    <= 1'b0;
			prev_l1_q    <= 1'b0;
			prev_r1_q    <= 1'b0;
			prev_r2_q    <= 1'b0;
			hold_left_q  <= 1'b0;
			hold_spin_q  <= 1'b0;
			hold_cross_q <= 1'b0;
			right_stop_q <= 16'd0;
			left_stop_q  <= 16'd0;
			spin_block_q <= 8'd0;
			no_right_q   <= 8'd0;
			cmd_q        <= CMD_STOP;
		end else if (in_take) begin
			prev_l2_q    <= sensor_l2;
			prev_l1_q    <= sensor_l1;
			prev_r1_q    <= sensor_r1;
			prev_r2_q    <= sensor_r2;
			hold_left_q  <= hold_left_n;
			hold_spin_q  <= hold_spin_n;
			hold_cross_q <= hold_cross_n;
			right_stop_q <= right_stop_n;
			left_stop_q  <= left_stop_n;
			spin_block_q <= spin_block_n;
			no_right_q   <= no_right_n;
			cmd_q        <= cmd_n;
		end
	end

	// result register; the last issued command always equals cmd_q
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			out_cmd_q     <= cmd_n;
			out_changed_q <= (cmd_n != cmd_q);
			out_started_q <= started_n;
		end
	end

	// at most one turn hold at a time
	a_one_hold: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({hold_left_q, hold_spin_q, hold_cross_q}))
		else $error("more than one turn hold active");

	// spin block only runs during a crossing right turn
	a_spin_in_cross: assert property (@(posedge clk) disable iff (!arst_n)
		(spin_block_q != 8'd0) |-> hold_cross_q)
		else $error("spin block count running outside crossing hold");

	// a crossing turn start always commands turn right
	a_start_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_started_q) |-> (out_cmd_q == CMD_TURN_RIGHT && hold_cross_q))
		else $error("right turn start without turn right command");

	// an accepted tick always leaves a result behind
	a_take_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> out_valid_q)
		else $error("accepted tick produced no result");

endmodule

`default_nettype wire

/* tb/tb_line_tracker_turn_controller_core.sv */
// Self-checking testbench for the line tracker turn controller core.
`default_nettype none

module tb_line_tracker_turn_controller_core;
	import lttc_pkg::*;

	// Register index with no register behind it; writes there must be dropped.
	localparam logic [CfgIdxW-1:0] RegUnmapped = 2'd3;

	localparam int unsigned CycleLimit    = 1000000;
	localparam int          DrainCycles   = 4;    // margin after draining; result register is one deep
	localparam int          HoldOffCycles = 300;  // long receiver stall, fills the block

	// Expected content of one result item.
	typedef struct packed {
		logic [2:0] cmd;
		logic       changed;
		logic       started;
	} turn_result_t;

	// Tracks the controller state tick by tick and holds the results still owed
	// by the block, oldest first.
	class turn_scoreboard;
		logic [7:0]   no_right_reload;
		logic [7:0]   spin_block_reload;
		logic [15:0]  stop_window;
		logic         last_l2, last_l1, last_r1, last_r2;
		logic         in_left_hold, in_spin_hold, in_cross_hold;
		logic [15:0]  right_marks, left_marks;
		logic [7:0]   spin_wait, no_right_wait;
		cmd_t         cur_cmd, issued_cmd;
		turn_result_t expected_q[$];
		int           errors;

		function new();
			no_right_reload   = NoRightReloadRst;
			spin_block_reload = SpinBlockReloadRst;
			stop_window       = StopWindowRst;
			{last_l2, last_l1, last_r1, last_r2} = '0;
			{in_left_hold, in_spin_hold, in_cross_hold} = '0;
			right_marks   = '0;
			left_marks    = '0;
			spin_wait     = '0;
			no_right_wait = '0;
			cur_cmd       = CMD_STOP;
			issued_cmd    = CMD_STOP;
			errors        = 0;
		endfunction

		function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] d);
			case (idx)
				REG_NO_RIGHT_RELOAD:   no_right_reload   = d[7:0];
				REG_SPIN_BLOCK_RELOAD: spin_block_reload = d[7:0];
				REG_STOP_WINDOW:       stop_window       = d;
				default: ;
			endcase
		endfunction

		// s = {l2, l1, mid, r1, r2}
		function void note_tick(logic [4:0] s);
			logic         l2, l1, mid, r1, r2;
			logic         started;
			turn_result_t r;
			{l2, l1, mid, r1, r2} = s;
			started = 1'b0;
			if (spin_wait != 0)
				spin_wait--;
			if (no_right_wait != 0)
				no_right_wait--;

			if (in_left_hold) begin
				if (l1 && !last_l1) begin
					in_left_hold  = 1'b0;
					no_right_wait = no_right_reload;
				end
			end else if (in_spin_hold) begin
				if (r1 && !last_r1)
					in_spin_hold = 1'b0;
			end else if (in_cross_hold) begin
				if (r1 && !last_r1 && spin_wait == 0)
					in_cross_hold = 1'b0;
			end else begin
				if (r2) begin
					if (right_marks != StopCountMax)
						right_marks++;
					if (l2 && left_marks != StopCountMax)
						left_marks++;
				end else if (!l2 && last_l2) begin
					if (!mid && left_marks == 0) begin
						right_marks  = '0;
						left_marks   = '0;
						cur_cmd      = CMD_TURN_LEFT;
						in_left_hold = 1'b1;
					end
				end else if (!l2 && !last_l2 && !last_r2) begin
					if (l1)
						cur_cmd = CMD_VEER_LEFT;
					else if (r1)
						cur_cmd = CMD_VEER_RIGHT;
					else if (!mid) begin
						cur_cmd      = CMD_TURN_RIGHT;
						in_spin_hold = 1'b1;
					end else
						cur_cmd = CMD_FORWARD;
					right_marks = '0;
					left_marks  = '0;
				end

				if (right_marks > 0 && right_marks < stop_window && !r2 &&
				    no_right_wait == 0) begin
					started       = 1'b1;
					right_marks   = '0;
					left_marks    = '0;
					spin_wait     = spin_block_reload;
					cur_cmd       = CMD_TURN_RIGHT;
					in_cross_hold = 1'b1;
				end
			end

			{last_l2, last_l1, last_r1, last_r2} = {l2, l1, r1, r2};
			r.cmd      = cur_cmd;
			r.changed  = (issued_cmd != cur_cmd);
			r.started  = started;
			issued_cmd = cur_cmd;
			expected_q.push_back(r);
		endfunction

		function void check_result(logic [2:0] cmd, logic chg, logic st);
			turn_result_t e;
			if (expected_q.size() == 0) begin
				$error("result item with no tick pending: drive_command=%0d", cmd);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (cmd !== e.cmd) begin
				$error("drive_command: expected %0d, got %0d", e.cmd, cmd);
				errors++;
			end
			if (chg !== e.changed) begin
				$error("command_changed: expected %0b, got %0b", e.changed, chg);
				errors++;
			end
			if (st !== e.started) begin
				$error("right_turn_started: expected %0b, got %0b", e.started, st);
				errors++;
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                sensor_l2 = 1'b0;
	logic                sensor_l1 = 1'b0;
	logic                sensor_mid = 1'b0;
	logic                sensor_r1 = 1'b0;
	logic                sensor_r2 = 1'b0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [2:0]          drive_command;
	logic                command_changed;
	logic                right_turn_started;
	logic                cfg_we = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;

	turn_scoreboard sb;
	bit             tx_idle_en;     // sender inserts random gaps
	bit             rx_idle_en;     // receiver inserts random stalls
	bit             hold_off_req;   // next receiver stall is the long one
	int             ticks_sent;

	line_tracker_turn_controller_core dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.sensor_l2          (sensor_l2),
		.sensor_l1          (sensor_l1),
		.sensor_mid         (sensor_mid),
		.sensor_r1          (sensor_r1),
		.sensor_r2          (sensor_r2),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.drive_command      (drive_command),
		.command_changed    (command_changed),
		.right_turn_started (right_turn_started),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data)
	);

	initial begin : clock_gen
		forever #5 clk = ~clk;
	end

	// Hard stop in case a handshake never completes.
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CycleLimit) begin
			@(posedge clk);
			cycles++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// One config register write. cfg_we is left high so back-to-back writes
	// never drop and raise it in the same step; the caller lowers it.
	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] d);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		sb.write_reg(idx, d);
	endtask

	// Writes all three registers, with junk in the unused upper bits of the
	// 8 bit ones, then a junk write to the unmapped index.
	task automatic configure(input logic [7:0] no_right, input logic [7:0] spin_block,
	                         input logic [15:0] window);
		logic [7:0] junk;
		junk = 8'($urandom());
		write_reg(REG_NO_RIGHT_RELOAD, {junk, no_right});
		junk = 8'($urandom());
		write_reg(REG_SPIN_BLOCK_RELOAD, {junk, spin_block});
		write_reg(REG_STOP_WINDOW, window);
		write_reg(RegUnmapped, 16'($urandom()));
		cfg_we <= 1'b0;
	endtask

	// Offers one tick, s = {l2, l1, mid, r1, r2}, and returns at the edge that
	// takes it. in_valid is only lowered when a gap follows, so a held valid
	// never sees two assignments in one step.
	task automatic send_tick(input logic [4:0] s);
		int gap;
		gap = tx_idle_en ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		{sensor_l2, sensor_l1, sensor_mid, sensor_r1, sensor_r2} <= s;
		do @(posedge clk); while (in_stall !== 1'b0);
		sb.note_tick(s);
		ticks_sent++;
	endtask

	// Track-like stimulus: mostly short sensor sequences a real course would
	// produce (stop marks, corners, spins), with plain noise mixed in.
	task automatic send_segment();
		logic [4:0] s;
		case ($urandom_range(0, 9))
			0, 1: begin
				// noise
				repeat ($urandom_range(1, 8)) begin
					s = 5'($urandom());
					send_tick(s);
				end
			end
			2, 3: begin
				// following the line, small drifts either way
				repeat ($urandom_range(1, 12)) begin
					s = 5'b00100;
					s[3] = ($urandom_range(0, 3) == 0);
					s[1] = ($urandom_range(0, 3) == 0);
					if ($urandom_range(0, 7) == 0)
						s[2] = 1'b0;
					send_tick(s);
				end
			end
			4, 5: begin
				// right stop marks, then the crossing turn and its release
				repeat ($urandom_range(1, 70)) begin
					s = 5'($urandom());
					s[0] = 1'b1;
					send_tick(s);
				end
				send_tick(5'b00100);
				repeat ($urandom_range(0, 60)) send_tick(5'b00100);
				send_tick(5'b00010);
				send_tick(5'b00100);
			end
			6: begin
				// left corner: outer left seen, lost, inner left picks it up
				repeat ($urandom_range(1, 6)) begin
					s = 5'b10100;
					s[3] = 1'($urandom_range(0, 1));
					send_tick(s);
				end
				s = 5'b00000;
				s[2] = ($urandom_range(0, 3) == 0);
				send_tick(s);
				repeat ($urandom_range(0, 20)) send_tick(5'b00100);
				send_tick(5'b01100);
				send_tick(5'b00100);
			end
			7: begin
				// line lost: spin right until the inner right sensor finds it
				repeat ($urandom_range(1, 3)) send_tick(5'b00000);
				send_tick(5'b00010);
				send_tick(5'b00100);
			end
			8: begin
				// both outer sensors on a cross line
				repeat ($urandom_range(1, 10)) begin
					s = 5'($urandom());
					s[4] = 1'b1;
					s[0] = 1'b1;
					send_tick(s);
				end
				send_tick(5'b00100);
			end
			default: begin
				// long straight, lets the no-right block run out
				repeat ($urandom_range(1, 100)) send_tick(5'b00100);
			end
		endcase
	endtask

	task automatic run_random(input int n);
		int start;
		start = ticks_sent;
		while (ticks_sent - start < n)
			send_segment();
	endtask

	// Waits until every expected result is out, plus a margin of DrainCycles.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// Result side: random stall before each item, the long one on request.
	initial begin : result_sink
		int wait_cycles;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			wait_cycles = rx_idle_en ? $urandom_range(0, 10) : 0;
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				wait_cycles  = HoldOffCycles;
			end
			if (wait_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
			sb.check_result(drive_command, command_changed, right_turn_started);
		end
	end

	initial begin : stimulus
		logic [4:0] seq[$];
		sb         = new();
		ticks_sent = 0;
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset register values: forward, veers, spin and its
		// release, left corner and its release, stop marks with right turns
		// still blocked after the left turn, extremes of the sensor word.
		seq = '{5'b00100, 5'b00100, 5'b01100, 5'b00110, 5'b00000, 5'b00000,
		        5'b00010, 5'b00100, 5'b10100, 5'b00000, 5'b01000, 5'b00100,
		        5'b00101, 5'b11111, 5'b00100, 5'b00000, 5'b00010};
		foreach (seq[i]) send_tick(seq[i]);
		drain();

		// Directed, short reloads: a crossing turn starts, the inner right
		// edge is ignored while the spin block runs, then releases it.
		configure(8'd0, 8'd3, 16'd50);
		seq = '{5'b00100, 5'b00101, 5'b00101, 5'b00100, 5'b00010, 5'b00000,
		        5'b00000, 5'b00000, 5'b00010, 5'b00100};
		foreach (seq[i]) send_tick(seq[i]);
		drain();

		configure(NoRightReloadRst, SpinBlockReloadRst, StopWindowRst);
		run_random(350);
		drain();

		// Top extremes, with one long receiver hold-off so the result
		// register fills and the input side stalls.
		configure(8'hFF, 8'hFF, 16'hFFFF);
		hold_off_req = 1'b1;
		run_random(250);
		drain();

		// Bottom extremes, back to back with no idling on either side.
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		configure(8'd0, 8'd0, 16'd1);
		run_random(250);
		drain();

		// Empty right-turn window: crossing turns must never start.
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		configure(8'd0, 8'd10, 16'd0);
		run_random(200);
		drain();

		configure(8'($urandom()), 8'($urandom()), 16'($urandom_range(1, 200)));
		run_random(350);
		drain();

		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire

/* filelist.f */
design/lttc_pkg.sv
design/line_tracker_turn_controller_core.sv
tb/tb_line_tracker_turn_controller_core.sv
